FILE: design/m3inv_pkg.sv
// ============================================================================
// m3inv_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverter.
// ============================================================================
package m3inv_pkg;

    localparam int ENTRY_W = 32;
    localparam int PROD_W  = 64;
    localparam int MAG_W   = 64;
    localparam int DET_W   = 97;
    localparam int DMAG_W  = 96;
    localparam int NUM_W   = 96;
    localparam int Q_W     = 33;
    localparam int N_ENT   = 9;
    localparam int DIV_STAGES = Q_W;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        entry_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
    } in_item_t;

    typedef struct packed {
        entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic   singular;
    } out_item_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } cof_t;

    localparam logic [ENTRY_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ENTRY_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

FILE: design/m3inv_if.sv
// ============================================================================
// m3inv_if
// Valid/ready channel that carries one payload of a given type.
// ============================================================================
interface m3inv_in_if;
    logic               valid;
    logic               ready;
    m3inv_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m3inv_out_if;
    logic                valid;
    logic                ready;
    m3inv_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/m3inv_cofactor.sv
// ============================================================================
// m3inv_cofactor
// Three-stage cofactor and determinant front end: products, cofactors, det.
// ============================================================================
module m3inv_cofactor (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  m3inv_pkg::in_item_t    in_data,
    output logic                   out_valid,
    output m3inv_pkg::in_item_t    out_mat,
    output m3inv_pkg::cof_t [8:0]  out_cof,
    output logic                   out_dneg,
    output logic [m3inv_pkg::DMAG_W-1:0] out_dmag,
    output logic                   out_zero
);
    typedef logic signed [m3inv_pkg::PROD_W-1:0] prod_t;
    typedef logic signed [m3inv_pkg::DET_W-1:0]  det_t;
    typedef logic signed [65:0]                  part_t;

    logic signed [31:0] a [9];
    prod_t p_next [18];
    prod_t p_reg  [18];
    m3inv_pkg::in_item_t m1_reg;
    logic v1_reg;

    m3inv_pkg::cof_t [8:0] c_next;
    m3inv_pkg::cof_t [8:0] c_reg;
    m3inv_pkg::in_item_t m2_reg;
    logic v2_reg;
    part_t tl_next [3];
    part_t tl_reg  [3];
    part_t th_next [3];
    part_t th_reg  [3];

    m3inv_pkg::cof_t [8:0] c3_reg;
    m3inv_pkg::in_item_t m3_reg;
    logic v3_reg;
    det_t det_next;
    logic dneg_reg, zero_reg;
    logic [m3inv_pkg::DMAG_W-1:0] dmag_reg;

    assign a[0] = in_data.a00; assign a[1] = in_data.a01; assign a[2] = in_data.a02;
    assign a[3] = in_data.a10; assign a[4] = in_data.a11; assign a[5] = in_data.a12;
    assign a[6] = in_data.a20; assign a[7] = in_data.a21; assign a[8] = in_data.a22;

    // stage 1: the eighteen 32x32 products, cyclic index form
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_next[2*(3*i+j)]   = prod_t'(a[3*((i+1)%3)+(j+1)%3])
                                    * prod_t'(a[3*((i+2)%3)+(j+2)%3]);
                p_next[2*(3*i+j)+1] = prod_t'(a[3*((i+1)%3)+(j+2)%3])
                                    * prod_t'(a[3*((i+2)%3)+(j+1)%3]);
            end
        end
    end

    // stage 2: cofactor as sign/magnitude, and first-row det terms split
    // into low and high 33-bit halves of the cofactor
    always_comb
    begin
        logic signed [64:0] d;
        logic signed [31:0] r0;
        logic signed [32:0] dlo;
        logic signed [32:0] dhi;
        for (int k = 0; k < 9; k++)
        begin
            d = 65'(p_reg[2*k]) - 65'(p_reg[2*k+1]);
            c_next[k].neg = d[64];
            c_next[k].mag = d[64] ? 64'(-d) : d[63:0];
        end
        for (int j = 0; j < 3; j++)
        begin
            d = 65'(p_reg[2*j]) - 65'(p_reg[2*j+1]);
            r0 = (j == 0) ? m1_reg.a00 : (j == 1) ? m1_reg.a01 : m1_reg.a02;
            dlo = {1'b0, d[31:0]};
            dhi = d[64:32];
            tl_next[j] = part_t'(r0) * part_t'(dlo);
            th_next[j] = part_t'(r0) * part_t'(dhi);
        end
    end

    // stage 3: recombine the halves and sum the det terms
    assign det_next = (det_t'(th_reg[0]) <<< 32) + det_t'(tl_reg[0])
                    + (det_t'(th_reg[1]) <<< 32) + det_t'(tl_reg[1])
                    + (det_t'(th_reg[2]) <<< 32) + det_t'(tl_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= p_next;
            m1_reg   <= in_data;
            c_reg    <= c_next;
            tl_reg   <= tl_next;
            th_reg   <= th_next;
            m2_reg   <= m1_reg;
            c3_reg   <= c_reg;
            m3_reg   <= m2_reg;
            dneg_reg <= det_next[m3inv_pkg::DET_W-1];
            dmag_reg <= det_next[m3inv_pkg::DET_W-1]
                      ? m3inv_pkg::DMAG_W'(-det_next) : det_next[m3inv_pkg::DMAG_W-1:0];
            zero_reg <= (det_next == '0);
        end
    end

    assign out_valid = v3_reg;
    assign out_mat   = m3_reg;
    assign out_cof   = c3_reg;
    assign out_dneg  = dneg_reg;
    assign out_dmag  = dmag_reg;
    assign out_zero  = zero_reg;
endmodule

FILE: design/m3inv_divider.sv
// ============================================================================
// m3inv_divider
// Pipelined restoring divider for nine quotients, one bit per stage.
// ============================================================================
module m3inv_divider (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  m3inv_pkg::in_item_t    in_mat,
    input  m3inv_pkg::cof_t [8:0]  in_cof,
    input  logic                   in_dneg,
    input  logic [m3inv_pkg::DMAG_W-1:0] in_dmag,
    input  logic                   in_zero,
    output logic                   out_valid,
    output m3inv_pkg::out_item_t   out_item
);
    localparam int NS = m3inv_pkg::DIV_STAGES;
    localparam int NW = m3inv_pkg::NUM_W;
    localparam int QW = m3inv_pkg::Q_W;
    // remainder tracks bits above the quotient window; quotient is < 2^33 when
    // unsaturated, bits above that only flag overflow
    localparam int RW = m3inv_pkg::DMAG_W + 1;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [NW-1:0] num;
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
    } lane_t;

    logic                         v_reg   [NS+1];
    lane_t [8:0]                  l_reg   [NS+1];
    lane_t [8:0]                  l_next  [NS+1];
    logic [m3inv_pkg::DMAG_W-1:0] d_reg   [NS+1];
    logic                         z_reg   [NS+1];
    m3inv_pkg::in_item_t          m_reg   [NS+1];
    logic [31:0] res [9];

    // prefix step: the top 63 numerator bits give a remainder < d or flag
    // overflow, since the quotient of those bits must be zero to fit 33 bits
    always_comb
    begin
        logic [NW-1:0] n;
        for (int k = 0; k < 9; k++)
        begin
            n = {in_cof[(k%3)*3 + k/3].mag, 32'd0};
            l_next[0][k].num = n;
            l_next[0][k].rem = RW'(n[NW-1:QW]);
            l_next[0][k].ovf = (RW'(n[NW-1:QW]) >= RW'(in_dmag));
            l_next[0][k].q   = '0;
            l_next[0][k].neg = in_cof[(k%3)*3 + k/3].neg ^ in_dneg;
        end
        for (int s = 1; s <= NS; s++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                logic [RW-1:0] r;
                r = {l_reg[s-1][k].rem[RW-2:0], l_reg[s-1][k].num[NS-s]};
                l_next[s][k] = l_reg[s-1][k];
                if (r >= RW'(d_reg[s-1]))
                begin
                    l_next[s][k].rem = r - RW'(d_reg[s-1]);
                    l_next[s][k].q[NS-s] = 1'b1;
                end
                else
                begin
                    l_next[s][k].rem = r;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_reg[0] <= l_next[0];
            d_reg[0] <= in_dmag;
            z_reg[0] <= in_zero;
            m_reg[0] <= in_mat;
            for (int s = 1; s <= NS; s++)
            begin
                l_reg[s] <= l_next[s];
                d_reg[s] <= d_reg[s-1];
                z_reg[s] <= z_reg[s-1];
                m_reg[s] <= m_reg[s-1];
            end
        end
    end

    // saturate and sign the quotients
    always_comb
    begin
        lane_t l;
        for (int k = 0; k < 9; k++)
        begin
            l = l_reg[NS][k];
            if (l.neg)
                res[k] = (l.ovf || l.q > QW'(33'h0_8000_0000)) ? m3inv_pkg::SAT_NEG
                       : 32'(-l.q);
            else
                res[k] = (l.ovf || l.q > QW'(33'h0_7FFF_FFFF)) ? m3inv_pkg::SAT_POS
                       : l.q[31:0];
        end
    end

    assign out_valid = v_reg[NS];
    always_comb
    begin
        if (z_reg[NS])
        begin
            out_item.r00 = m_reg[NS].a00; out_item.r01 = m_reg[NS].a01;
            out_item.r02 = m_reg[NS].a02; out_item.r10 = m_reg[NS].a10;
            out_item.r11 = m_reg[NS].a11; out_item.r12 = m_reg[NS].a12;
            out_item.r20 = m_reg[NS].a20; out_item.r21 = m_reg[NS].a21;
            out_item.r22 = m_reg[NS].a22;
        end
        else
        begin
            out_item.r00 = res[0]; out_item.r01 = res[1]; out_item.r02 = res[2];
            out_item.r10 = res[3]; out_item.r11 = res[4]; out_item.r12 = res[5];
            out_item.r20 = res[6]; out_item.r21 = res[7]; out_item.r22 = res[8];
        end
        out_item.singular = z_reg[NS];
    end
endmodule

FILE: design/mat3_inverse.sv
// ============================================================================
// mat3_inverse
// Streaming 3x3 Q16.16 matrix inverter (adjugate over determinant).
// ============================================================================
// Usage:
//   in  : one matrix per item, entries a00..a22 (signed Q16.16).
//   out : one result per item, r00..r22 (inverse, saturated, truncated
//         toward zero) and singular; a zero determinant returns the input
//         entries unchanged with singular set.
// Pipeline from input accept to output valid: products, cofactors and
//   determinant stages, 1 prefix stage, 33 one-bit divider stages, and
//   1 output register.
// Throughput: one item per cycle while the output does not stall; the
//   one-bit-per-stage divider pipeline sets the depth, not the rate.
// Reset: all valid bits clear; the pipeline is empty and in.ready is high.
// Stall: when out.ready is low and the output register is full, the whole
//   pipeline holds; in.ready drops with it, so nothing is lost or repeated.
// ============================================================================
module mat3_inverse (
    input  logic        clk,
    input  logic        rst_n,
    m3inv_in_if.sink    in,
    m3inv_out_if.source out
);
    logic adv;
    logic cf_valid, dv_valid;
    m3inv_pkg::in_item_t cf_mat;
    m3inv_pkg::cof_t [8:0] cf_cof;
    logic cf_dneg, cf_zero;
    logic [m3inv_pkg::DMAG_W-1:0] cf_dmag;
    m3inv_pkg::out_item_t dv_item;
    logic out_valid_reg;
    m3inv_pkg::out_item_t out_data_reg;

    // advance whenever the output register is free or being drained
    assign adv      = !out_valid_reg || out.ready;
    assign in.ready = adv;

    m3inv_cofactor u_cof (
        .clk, .rst_n, .adv,
        .in_valid (in.valid),
        .in_data  (in.data),
        .out_valid(cf_valid),
        .out_mat  (cf_mat),
        .out_cof  (cf_cof),
        .out_dneg (cf_dneg),
        .out_dmag (cf_dmag),
        .out_zero (cf_zero)
    );

    m3inv_divider u_div (
        .clk, .rst_n, .adv,
        .in_valid (cf_valid),
        .in_mat   (cf_mat),
        .in_cof   (cf_cof),
        .in_dneg  (cf_dneg),
        .in_dmag  (cf_dmag),
        .in_zero  (cf_zero),
        .out_valid(dv_valid),
        .out_item (dv_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= dv_item;
    end

    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    a_ready_adv: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready == (!out.valid || out.ready))
        else $error("ready not tied to output drain");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.data))
        else $error("stalled result changed");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.ready && !dv_valid |=> !out.valid)
        else $error("result repeated");
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Checks the 3x3 Q16.16 matrix inverter against an exact adjugate predictor.
// A queue-fed driver offers matrices under several idling phases; a monitor
// compares every returned inverse as a whole with the oldest prediction.
// ============================================================================
module tb;

    logic clk;
    logic rst_n;

    m3inv_in_if  in_ch ();
    m3inv_out_if out_ch ();

    mat3_inverse dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    // Idling phases: percent of cycles the sender idles / receiver stalls
    typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH, PH_HOLD} phase_t;

    m3inv_pkg::in_item_t  pending_mats [$];
    m3inv_pkg::out_item_t expected_inv [$];
    phase_t    phase;
    int        src_idle_pct;
    int        snk_stall_pct;
    int        hold_cycles;
    bit        hold_started;
    int        errors = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Saturate a signed quotient (sign and magnitude) to Q16.16
    function automatic m3inv_pkg::entry_t sat_q(logic neg, logic [127:0] q);
        if (neg)
            return (q > 128'h8000_0000) ? m3inv_pkg::entry_t'(m3inv_pkg::SAT_NEG)
                                        : m3inv_pkg::entry_t'(-q[31:0]);
        return (q > 128'h7FFF_FFFF) ? m3inv_pkg::entry_t'(m3inv_pkg::SAT_POS)
                                    : m3inv_pkg::entry_t'(q[31:0]);
    endfunction

    // Predict the inverse: cyclic-index cofactors give signed cofactors
    function automatic m3inv_pkg::out_item_t invert_mat(m3inv_pkg::in_item_t m);
        logic signed [31:0]   a [3][3];
        logic signed [127:0]  c [3][3];
        logic signed [127:0]  det;
        logic [127:0]         dmag;
        logic [127:0]         num;
        logic [127:0]         cmag;
        m3inv_pkg::entry_t    r [9];
        m3inv_pkg::out_item_t res;
        int                   r1, r2, c1, c2;
        a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
        a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
        a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                r1 = (i + 1) % 3; r2 = (i + 2) % 3;
                c1 = (j + 1) % 3; c2 = (j + 2) % 3;
                c[i][j] = 128'(a[r1][c1]) * 128'(a[r2][c2])
                        - 128'(a[r1][c2]) * 128'(a[r2][c1]);
            end
        det = 0;
        for (int j = 0; j < 3; j++)
            det += 128'(a[0][j]) * c[0][j];
        if (det == 0)
        begin
            res = {m, 1'b1};
            return res;
        end
        dmag = det[127] ? -det : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                cmag = c[j][i][127] ? -c[j][i] : c[j][i];
                num  = cmag << 32;
                r[i*3+j] = sat_q(c[j][i][127] != det[127], num / dmag);
            end
        res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0};
        return res;
    endfunction

    // Driver: offer the head of the queue, drop it once accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_inv.push_back(invert_mat(in_ch.data));
                void'(pending_mats.pop_front());
            end
            // Decide on the queue as it will stand after this edge
            if ((in_ch.valid && in_ch.ready ? pending_mats.size() > 0
                                            : pending_mats.size() > 0)
                && $urandom_range(99) >= src_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_mats[0];
            end
            else if (!(in_ch.valid && !in_ch.ready))
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= 0;
            hold_started <= 1'b0;
        end
        else if (phase == PH_HOLD && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_cycles  <= 300;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        m3inv_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_inv.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_ch.data);
                errors++;
            end
            else
            begin
                want = expected_inv.pop_front();
                if (want !== out_ch.data)
                begin
                    $display("%0t: mismatch expected %h", $time, want);
                    $display("%0t:          actual   %h", $time, out_ch.data);
                    errors++;
                end
            end
        end
    end

    function automatic m3inv_pkg::entry_t rand_entry();
        case ($urandom_range(5))
            0: return m3inv_pkg::entry_t'($urandom);
            1: return m3inv_pkg::entry_t'($urandom_range(8)) <<< 16;
            2: return -(m3inv_pkg::entry_t'($urandom_range(8)) <<< 16);
            3: return m3inv_pkg::entry_t'($urandom_range(2000)) - 1000;
            4: return $urandom_range(1) ? m3inv_pkg::entry_t'(m3inv_pkg::SAT_POS)
                                        : m3inv_pkg::entry_t'(m3inv_pkg::SAT_NEG);
            default: return m3inv_pkg::entry_t'($signed($urandom_range(32'h3_FFFF)))
                            - 32'h2_0000;
        endcase
    endfunction

    function automatic m3inv_pkg::in_item_t rand_mat();
        m3inv_pkg::in_item_t m;
        m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // Make some singular: copy row 0 into row 1
        if ($urandom_range(9) == 0)
        begin
            m.a10 = m.a00; m.a11 = m.a01; m.a12 = m.a02;
        end
        return m;
    endfunction

    task automatic wait_drained();
        while (pending_mats.size() > 0 || in_ch.valid || expected_inv.size() > 0)
            @(posedge clk);
    endtask

    localparam m3inv_pkg::entry_t ONE = 32'sh0001_0000;
    localparam m3inv_pkg::entry_t MAXV = m3inv_pkg::entry_t'(m3inv_pkg::SAT_POS);
    localparam m3inv_pkg::entry_t MINV = m3inv_pkg::entry_t'(m3inv_pkg::SAT_NEG);

    initial
    begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        phase         = PH_NONE;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, scaled, extremes, zero, singular, overflow
        pending_mats.push_back({ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE});
        pending_mats.push_back({ONE<<<1, 32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd0,
                                32'sd0, 32'sd0, ONE<<<2});
        pending_mats.push_back('0);
        pending_mats.push_back({9{MAXV}});
        pending_mats.push_back({9{MINV}});
        pending_mats.push_back({MINV, 32'sd0, 32'sd0, 32'sd0,
                                MINV, 32'sd0, 32'sd0, 32'sd0,
                                MINV});
        pending_mats.push_back({MAXV, 32'sd0, 32'sd0, 32'sd0,
                                MAXV, 32'sd0, 32'sd0, 32'sd0,
                                MAXV});
        pending_mats.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0,
                                32'sd0, 32'sd0, 32'sd1});
        pending_mats.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0,
                                32'sd0, 32'sd0, 32'sd1});
        pending_mats.push_back({ONE, ONE<<<1, ONE*3, ONE<<<2, ONE*5, ONE*6,
                                ONE*7, ONE<<<3, ONE*9});
        pending_mats.push_back({ONE<<<1, -ONE, 32'sd0, -ONE, ONE<<<1, -ONE,
                                32'sd0, -ONE, ONE<<<1});
        pending_mats.push_back({ONE*3, 32'sd0, 32'sd0, 32'sd0, ONE*3, 32'sd0,
                                32'sd0, 32'sd0, ONE*3});
        pending_mats.push_back({32'sd0, ONE, 32'sd0, ONE, 32'sd0, 32'sd0,
                                32'sd0, 32'sd0, -ONE});
        pending_mats.push_back({32'sh7FFF_0000, 32'sd1, 32'sd5, 32'sd3, 32'sd7,
                                -32'sd2, 32'sd4, -32'sd9, 32'sd6});
        wait_drained();

        // Random phases, including a long receiver hold-off
        for (int ph = 0; ph < 5; ph++)
        begin
            phase = phase_t'(ph);
            case (phase)
                PH_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                PH_SRC:  begin src_idle_pct = 72; snk_stall_pct = 0;  end
                PH_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 72; end
                PH_BOTH: begin src_idle_pct = 6;  snk_stall_pct = 6;  end
                default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            endcase
            for (int k = 0; k < 150; k++)
                pending_mats.push_back(rand_mat());
            wait_drained();
        end
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
